[rtl/core/text_console_register_device_unit_defines.svh]
// ---------------------------------------------------------------------------
// Text console register device: assertion macros
// Shared assertion wrappers, clocked on clk, for the console device modules.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_REGISTER_DEVICE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_REGISTER_DEVICE_UNIT_DEFINES_SVH

// A property that is checked only outside of reset.
`define TCRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is checked at every edge, reset included.
`define TCRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tcrd_pkg.sv]
// ---------------------------------------------------------------------------
// Text console register device: package
// Sizes, bus map codes, operation bundles and the screen index helper.
// ---------------------------------------------------------------------------
package tcrd_pkg;

  // Screen and keyboard sizes.
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 50;
  localparam int KEY_DEPTH   = 16;
  localparam int RING_SLOTS  = 16;

  // Field and register widths.
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 8;
  localparam int DATA_W     = 8;
  localparam int ROW_W      = 6;
  localparam int PTR_W      = 4;
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int CHAR_DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int BLIT_REGS  = 7;
  localparam int BLIT_IW    = $clog2(BLIT_REGS);
  localparam int WIN_BASE   = 16;

  // Reset contents.
  localparam logic [DATA_W-1:0] SPACE_CHAR       = 8'd32;
  localparam logic [DATA_W-1:0] CURSOR_STYLE_RST = 8'd2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd2;

  // Bus map.
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_ROW   = 8'd0;
  localparam logic [ADDR_W-1:0] ADDR_CURSOR_COL   = 8'd1;
  localparam logic [ADDR_W-1:0] ADDR_CURSOR_ROW   = 8'd2;
  localparam logic [ADDR_W-1:0] ADDR_CURSOR_STYLE = 8'd3;
  localparam logic [ADDR_W-1:0] ADDR_KEY_HEAD     = 8'd4;
  localparam logic [ADDR_W-1:0] ADDR_KEY_TAIL     = 8'd5;
  localparam logic [ADDR_W-1:0] ADDR_KEY_DATA     = 8'd6;
  localparam logic [ADDR_W-1:0] ADDR_BLIT_FIRST   = 8'd7;
  localparam logic [ADDR_W-1:0] ADDR_BLIT_LAST    = 8'd13;
  localparam logic [ADDR_W-1:0] ADDR_WIN_FIRST    = ADDR_W'(WIN_BASE);
  localparam logic [ADDR_W-1:0] ADDR_WIN_LAST     = ADDR_W'(WIN_BASE + SCREEN_COLS - 1);

  // Operation bundle for the keyboard ring.
  typedef struct packed {
    logic              head_we;
    logic              tail_we;
    logic              data_we;
    logic              push;
    logic [DATA_W-1:0] wdata;
  } tcrd_ring_op_t;

  // Operation bundle for the character store.
  typedef struct packed {
    logic               rd;
    logic               we;
    logic [CHAR_AW-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } tcrd_mem_op_t;

  // Linear character store index of a row and column.
  function automatic logic [CHAR_AW-1:0] char_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
    logic [CHAR_AW:0] idx;
    idx = (CHAR_AW+1)'(row) * (CHAR_AW+1)'(SCREEN_COLS) + (CHAR_AW+1)'(col);
    return idx[CHAR_AW-1:0];
  endfunction

endpackage

[rtl/core/tcrd_key_ring.sv]
// ---------------------------------------------------------------------------
// Keyboard ring
// Sixteen-slot key ring with software visible head and tail pointers.
// ---------------------------------------------------------------------------
module tcrd_key_ring (
  input  logic                         clk,
  input  logic                         rst,
  input  tcrd_pkg::tcrd_ring_op_t      op,
  output logic [tcrd_pkg::PTR_W-1:0]   head,
  output logic [tcrd_pkg::PTR_W-1:0]   tail,
  output logic [tcrd_pkg::DATA_W-1:0]  head_data
);
  import tcrd_pkg::*;

  `include "text_console_register_device_unit_defines.svh"

  logic [DATA_W-1:0] ring [RING_SLOTS];
  logic [PTR_W:0]    tail_inc;
  logic [PTR_W-1:0]  tail_adv;
  logic              full;

  // The advanced tail wraps once it reaches the configured depth.
  always_comb begin
    tail_inc = {1'b0, tail} + (PTR_W+1)'(1);
    tail_adv = (tail_inc >= (PTR_W+1)'(KEY_DEPTH)) ? '0 : tail_inc[PTR_W-1:0];
    full     = (tail_adv == head);
  end

  assign head_data = ring[head];

  // Pointer and slot updates; at most one operation is active per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      for (int i = 0; i < RING_SLOTS; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (op.head_we) begin
        head <= op.wdata[PTR_W-1:0];
      end
      if (op.tail_we) begin
        tail <= op.wdata[PTR_W-1:0];
      end
      if (op.data_we) begin
        ring[head] <= op.wdata;
      end
      if (op.push && !full) begin
        ring[tail] <= op.wdata;
        tail       <= tail_adv;
      end
    end
  end

  // A stored key never makes the ring look empty.
  `TCRD_ASSERT(a_push_keeps_gap, (op.push && !full) |=> (tail != head), "push closed the ring")

endmodule

[rtl/core/tcrd_char_mem.sv]
// ---------------------------------------------------------------------------
// Character store
// Single-port screen memory with registered read and a clearing pass.
// ---------------------------------------------------------------------------
module tcrd_char_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  tcrd_pkg::tcrd_mem_op_t       op,
  output logic [tcrd_pkg::DATA_W-1:0]  rdata,
  output logic                         busy
);
  import tcrd_pkg::*;

  `include "text_console_register_device_unit_defines.svh"

  logic [DATA_W-1:0]  mem [CHAR_DEPTH];
  logic [CHAR_AW-1:0] clr_idx;

  // After reset every entry is swept to a space, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + CHAR_AW'(1);
      if (clr_idx == CHAR_AW'(CHAR_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Memory port; the read word holds until the next read.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= SPACE_CHAR;
    end else if (op.we) begin
      mem[op.addr] <= op.wdata;
    end
    if (op.rd) begin
      rdata <= mem[op.addr];
    end
  end

  `TCRD_ASSERT(a_clear_once, !busy |=> !busy, "clearing pass restarted without reset")
  `TCRD_ASSERT(a_no_access_in_clear, busy |-> !(op.rd || op.we), "access during clearing pass")

endmodule

[rtl/core/text_console_register_device_unit.sv]
// ---------------------------------------------------------------------------
// Text console register device
// Byte-wide bus device with a character screen, cursor and keyboard ring.
// ---------------------------------------------------------------------------
// Each input word is a bus read, a bus write or a key press, and one word is
// taken per clock cycle while in_stall is low. A word waits in the input
// register, where all state is updated and any read is launched; a read waits
// there while the output is stalled. A read result is registered on the output
// and holds while out_stall is high. The screen read goes through the
// registered port of the single character memory. After reset the character
// memory is filled with spaces by a clearing pass over all SCREEN_COLS *
// SCREEN_ROWS entries (4000), during which in_stall stays high.
module text_console_register_device_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcrd_pkg::KIND_W-1:0]  kind,
  input  logic [tcrd_pkg::ADDR_W-1:0]  address,
  input  logic [tcrd_pkg::DATA_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcrd_pkg::DATA_W-1:0]  read_data
);
  import tcrd_pkg::*;

  `include "text_console_register_device_unit_defines.svh"

  // Input register.
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_value;

  // Device registers.
  logic [ROW_W-1:0]  window_row;
  logic [DATA_W-1:0] cursor_col;
  logic [DATA_W-1:0] cursor_row;
  logic [DATA_W-1:0] cursor_style;
  logic [DATA_W-1:0] blit_regs [BLIT_REGS];

  // Output register.
  logic              out_from_mem;
  logic [DATA_W-1:0] out_data;

  // Control and decode.
  logic              accept;
  logic              out_free;
  logic              s1_go;
  logic              is_rd;
  logic              is_wr;
  logic              in_win;
  logic [COL_W-1:0]  win_col;
  logic [BLIT_IW-1:0] blit_idx;
  logic              in_blit;
  logic [DATA_W-1:0] reg_rdata;

  tcrd_ring_op_t     ring_op;
  tcrd_mem_op_t      mem_op;
  logic [PTR_W-1:0]  key_head;
  logic [PTR_W-1:0]  key_tail;
  logic [DATA_W-1:0] key_data;
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_busy;

  // Handshake: a read leaves the input register only when the output is free.
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && ((s1_kind != KIND_READ) || out_free);
  assign in_stall = mem_busy || (s1_valid && !s1_go);
  assign accept   = in_valid && !in_stall;
  assign is_rd    = s1_go && (s1_kind == KIND_READ);
  assign is_wr    = s1_go && (s1_kind == KIND_WRITE);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= kind;
      s1_addr  <= address;
      s1_value <= value;
    end
  end

  // Address decode.
  always_comb begin
    in_win   = s1_addr inside {[ADDR_WIN_FIRST:ADDR_WIN_LAST]};
    in_blit  = s1_addr inside {[ADDR_BLIT_FIRST:ADDR_BLIT_LAST]};
    win_col  = COL_W'(s1_addr - ADDR_WIN_FIRST);
    blit_idx = BLIT_IW'(s1_addr - ADDR_BLIT_FIRST);
  end

  // Operations for the character store and the keyboard ring.
  always_comb begin
    mem_op.rd      = is_rd && in_win;
    mem_op.we      = is_wr && in_win;
    mem_op.addr    = char_index(window_row, win_col);
    mem_op.wdata   = s1_value;
    ring_op.head_we = is_wr && (s1_addr == ADDR_KEY_HEAD);
    ring_op.tail_we = is_wr && (s1_addr == ADDR_KEY_TAIL);
    ring_op.data_we = is_wr && (s1_addr == ADDR_KEY_DATA);
    ring_op.push    = s1_go && (s1_kind == KIND_KEY);
    ring_op.wdata   = s1_value;
  end

  // Register writes; the window row is clamped to the last screen row.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_row   <= '0;
      cursor_col   <= '0;
      cursor_row   <= '0;
      cursor_style <= CURSOR_STYLE_RST;
      for (int i = 0; i < BLIT_REGS; i++) begin
        blit_regs[i] <= '0;
      end
    end else if (is_wr) begin
      case (s1_addr)
        ADDR_WINDOW_ROW: begin
          window_row <= (s1_value > DATA_W'(SCREEN_ROWS - 1)) ?
                        ROW_W'(SCREEN_ROWS - 1) : s1_value[ROW_W-1:0];
        end
        ADDR_CURSOR_COL:   cursor_col   <= s1_value;
        ADDR_CURSOR_ROW:   cursor_row   <= s1_value;
        ADDR_CURSOR_STYLE: cursor_style <= s1_value;
        default: begin
          if (in_blit) begin
            blit_regs[blit_idx] <= s1_value;
          end
        end
      endcase
    end
  end

  // Register read data; unmapped addresses read as zero.
  always_comb begin
    case (s1_addr)
      ADDR_WINDOW_ROW:   reg_rdata = DATA_W'(window_row);
      ADDR_CURSOR_COL:   reg_rdata = cursor_col;
      ADDR_CURSOR_ROW:   reg_rdata = cursor_row;
      ADDR_CURSOR_STYLE: reg_rdata = cursor_style;
      ADDR_KEY_HEAD:     reg_rdata = DATA_W'(key_head);
      ADDR_KEY_TAIL:     reg_rdata = DATA_W'(key_tail);
      ADDR_KEY_DATA:     reg_rdata = key_data;
      default:           reg_rdata = in_blit ? blit_regs[blit_idx] : '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_rd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_rd) begin
      out_from_mem <= in_win;
      out_data     <= reg_rdata;
    end
  end

  assign read_data = out_from_mem ? mem_rdata : out_data;

  tcrd_key_ring u_key_ring (
    .clk       (clk),
    .rst       (rst),
    .op        (ring_op),
    .head      (key_head),
    .tail      (key_tail),
    .head_data (key_data)
  );

  tcrd_char_mem u_char_mem (
    .clk   (clk),
    .rst   (rst),
    .op    (mem_op),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  `TCRD_ASSERT(a_clear_blocks_input, mem_busy |-> in_stall, "word taken during clearing pass")
  `TCRD_ASSERT(a_read_gives_word, is_rd |=> out_valid, "read launched without result")

endmodule

[tb/tb_text_console_register_device_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the text console register device
// Sends bus reads, bus writes and key presses through the input channel, with
// random idle gaps on the input and random stalls on the output. A built-in
// model of the console predicts each read word, and every returned word is
// checked in order against it.
// ----------------------------------------------------------------------------
module tb_text_console_register_device_unit;
  import tcrd_pkg::*;

  // Kind code that the device ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Number of counted input words, directed part included, that ends the random part.
  localparam int WORD_TARGET = 1850;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] kind = KIND_READ;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] read_data;

  // Stimulus words waiting to be sent, and read words still owed by the device.
  bus_word_t         word_queue[$];
  logic [DATA_W-1:0] owed_reads[$];
  bus_word_t         cur_word;
  int                counted_words = 0;
  int                error_count = 0;

  // Console state as the testbench expects it.
  logic [DATA_W-1:0] screen_mem[CHAR_DEPTH];
  logic [ROW_W-1:0]  win_row;
  logic [DATA_W-1:0] cur_col;
  logic [DATA_W-1:0] cur_row;
  logic [DATA_W-1:0] cur_style;
  logic [PTR_W-1:0]  ring_head;
  logic [PTR_W-1:0]  ring_tail;
  logic [DATA_W-1:0] ring_mem[RING_SLOTS];
  logic [DATA_W-1:0] blit_mem[BLIT_REGS];

  // Idle and stall bookkeeping for both channels.
  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;

  text_console_register_device_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .address   (address),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short pauses, a few long ones.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic bit is_window(input logic [ADDR_W-1:0] a);
    return a >= ADDR_WIN_FIRST && a <= ADDR_WIN_LAST;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Applies one accepted word to the expected console state; a read also
  // leaves the byte it should return.
  task automatic console_step(input bus_word_t w);
    logic [DATA_W-1:0] rd;
    int unsigned       scr_idx;
    logic [PTR_W-1:0]  next_tail;
    scr_idx = int'(win_row) * SCREEN_COLS + int'(w.addr) - WIN_BASE;
    case (w.kind)
      KIND_READ: begin
        rd = '0;
        if (is_window(w.addr)) begin
          rd = screen_mem[scr_idx];
        end else if (w.addr >= ADDR_BLIT_FIRST && w.addr <= ADDR_BLIT_LAST) begin
          rd = blit_mem[w.addr - ADDR_BLIT_FIRST];
        end else begin
          case (w.addr)
            ADDR_WINDOW_ROW:   rd = DATA_W'(win_row);
            ADDR_CURSOR_COL:   rd = cur_col;
            ADDR_CURSOR_ROW:   rd = cur_row;
            ADDR_CURSOR_STYLE: rd = cur_style;
            ADDR_KEY_HEAD:     rd = DATA_W'(ring_head);
            ADDR_KEY_TAIL:     rd = DATA_W'(ring_tail);
            ADDR_KEY_DATA:     rd = ring_mem[ring_head];
            default:           rd = '0;
          endcase
        end
        owed_reads.push_back(rd);
      end
      KIND_WRITE: begin
        if (is_window(w.addr)) begin
          screen_mem[scr_idx] = w.data;
        end else if (w.addr >= ADDR_BLIT_FIRST && w.addr <= ADDR_BLIT_LAST) begin
          blit_mem[w.addr - ADDR_BLIT_FIRST] = w.data;
        end else begin
          case (w.addr)
            ADDR_WINDOW_ROW:
              win_row = (w.data > SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1) : w.data[ROW_W-1:0];
            ADDR_CURSOR_COL:   cur_col = w.data;
            ADDR_CURSOR_ROW:   cur_row = w.data;
            ADDR_CURSOR_STYLE: cur_style = w.data;
            ADDR_KEY_HEAD:     ring_head = w.data[PTR_W-1:0];
            ADDR_KEY_TAIL:     ring_tail = w.data[PTR_W-1:0];
            ADDR_KEY_DATA:     ring_mem[ring_head] = w.data;
            default: ;
          endcase
        end
      end
      KIND_KEY: begin
        // The key is dropped when the ring is full.
        next_tail = (int'(ring_tail) + 1 >= KEY_DEPTH) ? '0 : ring_tail + 1'b1;
        if (next_tail != ring_head) begin
          ring_mem[ring_tail] = w.data;
          ring_tail = next_tail;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [KIND_W-1:0] k, input int a, input int v);
    bus_word_t w;
    w.kind = k;
    w.addr = ADDR_W'(a);
    w.data = DATA_W'(v);
    word_queue.push_back(w);
    // Unused kinds and unmapped writes leave the device untouched.
    if (!(k == KIND_UNUSED || (k == KIND_WRITE && w.addr > ADDR_BLIT_LAST && !is_window(w.addr))))
      counted_words++;
  endtask

  // Input driver: presents queued words, with idle gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) console_step(cur_word);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          cur_word = word_queue.pop_front();
          kind     <= cur_word.kind;
          address  <= cur_word.addr;
          value    <= cur_word.data;
          in_valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
          end else if ($urandom_range(0, 49) == 0) begin
            in_calm = $urandom_range(40, 200);
          end else if ($urandom_range(0, 1) == 1) begin
            in_gap = pause_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each read word and stalls the output at random.
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_reads.size() == 0) begin
          report_mismatch($sformatf("read word 0x%02h with no read pending", read_data));
        end else begin
          want = owed_reads.pop_front();
          if (read_data !== want)
            report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h", read_data, want));
        end
      end
      if (out_hold == 0) begin
        if (out_calm > 0) begin
          out_calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          out_calm = $urandom_range(40, 200);
        end else if ($urandom_range(0, 3) == 0) begin
          out_hold = pause_len();
        end
      end
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  // Reset, stimulus and end of run.
  initial begin
    int sel;
    int reps;
    int head_ptr;
    int tail_ptr;
    int a;

    for (int i = 0; i < CHAR_DEPTH; i++) screen_mem[i] = SPACE_CHAR;
    for (int i = 0; i < RING_SLOTS; i++) ring_mem[i] = '0;
    for (int i = 0; i < BLIT_REGS; i++) blit_mem[i] = '0;
    win_row   = '0;
    cur_col   = '0;
    cur_row   = '0;
    cur_style = CURSOR_STYLE_RST;
    ring_head = '0;
    ring_tail = '0;

    // Directed: reset values, window edges, unmapped holes, row clamping,
    // key entry, ring data access and the unused kind.
    push_word(KIND_READ, ADDR_WINDOW_ROW, 0);
    push_word(KIND_READ, ADDR_CURSOR_STYLE, 0);
    push_word(KIND_READ, ADDR_KEY_DATA, 0);
    push_word(KIND_READ, ADDR_BLIT_LAST, 0);
    push_word(KIND_READ, ADDR_BLIT_LAST + 1, 0);
    push_word(KIND_READ, ADDR_WIN_FIRST - 1, 0);
    push_word(KIND_READ, ADDR_WIN_FIRST, 0);
    push_word(KIND_READ, ADDR_WIN_LAST, 0);
    push_word(KIND_READ, ADDR_WIN_LAST + 1, 0);
    push_word(KIND_READ, 255, 0);
    push_word(KIND_WRITE, ADDR_WINDOW_ROW, 255);
    push_word(KIND_READ, ADDR_WINDOW_ROW, 0);
    push_word(KIND_WRITE, ADDR_WIN_FIRST, 8'hAA);
    push_word(KIND_WRITE, ADDR_WIN_LAST, 8'h55);
    push_word(KIND_READ, ADDR_WIN_FIRST, 0);
    push_word(KIND_READ, ADDR_WIN_LAST, 0);
    push_word(KIND_KEY, 255, 8'hFF);
    push_word(KIND_KEY, 0, 8'h00);
    push_word(KIND_READ, ADDR_KEY_TAIL, 0);
    push_word(KIND_READ, ADDR_KEY_DATA, 0);
    push_word(KIND_WRITE, ADDR_KEY_DATA, 8'h81);
    push_word(KIND_READ, ADDR_KEY_DATA, 0);
    push_word(KIND_WRITE, ADDR_BLIT_LAST + 1, 8'hFF);
    push_word(KIND_UNUSED, 255, 8'hFF);
    push_word(KIND_READ, ADDR_KEY_HEAD, 0);

    // Random part, built mostly from short well-formed sequences.
    while (counted_words < WORD_TARGET) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1: begin
          // Register write followed by a read back.
          a = $urandom_range(ADDR_WINDOW_ROW, ADDR_BLIT_LAST);
          push_word(KIND_WRITE, a, $urandom_range(0, 255));
          push_word(KIND_READ, a, $urandom_range(0, 255));
        end
        2, 3: begin
          // Select a row, then work within the window.
          push_word(KIND_WRITE, ADDR_WINDOW_ROW,
                    ($urandom_range(0, 3) != 0) ? $urandom_range(0, SCREEN_ROWS - 1)
                                                : $urandom_range(0, 255));
          reps = $urandom_range(2, 8);
          for (int i = 0; i < reps; i++) begin
            a = ($urandom_range(0, 4) == 0)
                  ? (($urandom_range(0, 1) == 1) ? ADDR_WIN_FIRST : ADDR_WIN_LAST)
                  : $urandom_range(ADDR_WIN_FIRST, ADDR_WIN_LAST);
            push_word(($urandom_range(0, 1) == 1) ? KIND_READ : KIND_WRITE, a,
                      $urandom_range(0, 255));
          end
        end
        4, 5: begin
          // Place the ring pointers, type keys (sometimes past full), drain.
          head_ptr = $urandom_range(0, 15);
          tail_ptr = ($urandom_range(0, 1) == 1) ? head_ptr : $urandom_range(0, 15);
          push_word(KIND_WRITE, ADDR_KEY_HEAD, ($urandom_range(0, 15) << 4) | head_ptr);
          push_word(KIND_WRITE, ADDR_KEY_TAIL, ($urandom_range(0, 15) << 4) | tail_ptr);
          reps = $urandom_range(1, 20);
          for (int i = 0; i < reps; i++)
            push_word(KIND_KEY, $urandom_range(0, 255), $urandom_range(0, 255));
          push_word(KIND_READ, ADDR_KEY_TAIL, 0);
          reps = $urandom_range(1, 18);
          for (int i = 0; i < reps; i++) begin
            push_word(KIND_READ, ADDR_KEY_DATA, 0);
            if ($urandom_range(0, 7) == 0)
              push_word(KIND_WRITE, ADDR_KEY_DATA, $urandom_range(0, 255));
            head_ptr = (head_ptr + 1) % RING_SLOTS;
            push_word(KIND_WRITE, ADDR_KEY_HEAD, head_ptr);
          end
          push_word(KIND_READ, ADDR_KEY_HEAD, 0);
        end
        6: begin
          // Unconstrained noise.
          reps = $urandom_range(1, 6);
          for (int i = 0; i < reps; i++)
            push_word(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        end
        7: begin
          // Unmapped addresses, both holes.
          a = ($urandom_range(0, 1) == 1) ? $urandom_range(ADDR_BLIT_LAST + 1, ADDR_WIN_FIRST - 1)
                                          : $urandom_range(ADDR_WIN_LAST + 1, 255);
          push_word(($urandom_range(0, 1) == 1) ? KIND_READ : KIND_WRITE, a,
                    $urandom_range(0, 255));
          push_word(KIND_READ, a, 0);
        end
        default: begin
          // Register reads.
          reps = $urandom_range(1, 4);
          for (int i = 0; i < reps; i++)
            push_word(KIND_READ, $urandom_range(ADDR_WINDOW_ROW, ADDR_BLIT_LAST),
                      $urandom_range(0, 255));
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every read to come back.
    do @(posedge clk);
    while (word_queue.size() > 0 || in_valid || owed_reads.size() > 0);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, well beyond the clearing pass plus the slowest legal run.
  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
